// ===== rtl/htw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types, codes and defaults of the hashed timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

    localparam int unsigned DEF_NUM_SLOTS   = 256;
    localparam int unsigned DEF_NUM_HANDLES = 32;
    localparam int unsigned GRAN_MAX        = 1000;

    localparam logic [9:0]  GRAN_RESET   = 10'd15;
    localparam logic [17:0] MAXTO_RESET  = 18'd3825;
    localparam logic [31:0] NONE_PENDING = 32'hFFFF_FFFF;

    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_UPD   = 3'd1;
    localparam logic [2:0] OP_CAN   = 3'd2;
    localparam logic [2:0] OP_ADV   = 3'd3;
    localparam logic [2:0] OP_NEXT  = 3'd4;
    localparam logic [2:0] OP_ISSET = 3'd5;

    localparam logic [1:0] MODE_ALWAYS = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd0;
    localparam logic [1:0] MODE_LATER  = 2'd2;
    localparam logic [1:0] MODE_SOONER = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EXPIRE = 2'd1;
    localparam logic [1:0] KIND_NEXT   = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LONG  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    localparam logic CFG_GRAN  = 1'b0;
    localparam logic CFG_MAXTO = 1'b1;

    typedef struct packed {
        logic        ins;
        logic        pdw;
        logic        clr;
        logic [4:0]  handle;
        logic [31:0] offset;
        logic [31:0] payload;
        logic [15:0] order;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic        found;
        logic [15:0] key;
        logic [4:0]  handle;
        logic [31:0] payload;
    } t_scan;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  handle;
        logic [31:0] data;
        logic        wp;
        logic        upd;
        logic [31:0] nt;
        logic [1:0]  err;
    } t_res;

endpackage

// ===== rtl/htw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_div
// Restoring divider, 32-bit dividend by 10-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module htw_div
    import htw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [9:0]  i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [9:0]  o_rem
);

    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [31:0] r_q;
    logic [9:0]  r_r;
    logic [9:0]  r_d;
    logic [10:0] w_tr;
    logic        w_ge;

    assign w_tr = {r_r, r_q[31]};
    assign w_ge = w_tr >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[30:0], w_ge};
            r_r <= w_ge ? 10'(w_tr - {1'b0, r_d}) : w_tr[9:0];
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// ===== rtl/htw_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_cell
// One timer entry; compares itself against the scan record passing through.
// ----------------------------------------------------------------------------
module htw_cell
    import htw_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int unsigned IDX       = 0,
    localparam int unsigned SW       = $clog2(NUM_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [SW-1:0] i_cmd_slot,
    input  logic [SW-1:0] i_wi,
    input  logic [15:0]   i_ic,
    input  logic          i_query,
    input  t_scan         i_scan,
    output t_scan         o_scan,
    output logic          o_pending,
    output logic [31:0]   o_offset
);

    logic          r_pend;
    logic [SW-1:0] r_slot;
    logic [31:0]   r_off;
    logic [31:0]   r_pay;
    logic [15:0]   r_ord;
    t_scan         r_scan;
    logic          w_hit;
    logic          w_match;
    logic [SW-1:0] w_dist;
    logic [15:0]   w_key;
    logic          w_take;

    assign w_hit   = {1'b0, i_cmd.handle} == 6'(IDX);
    assign w_dist  = (r_slot >= i_wi) ? SW'(r_slot - i_wi)
                   : SW'((SW+1)'(r_slot) + (SW+1)'(NUM_SLOTS) - (SW+1)'(i_wi));
    assign w_match = r_pend && (i_query || r_slot == i_wi);
    assign w_key   = i_query ? 16'(w_dist) : 16'(i_ic - r_ord);
    assign w_take  = i_scan.valid && w_match && (!i_scan.found || w_key < i_scan.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= 1'b0;
            r_scan.valid <= 1'b0;
        end else begin
            r_scan.valid <= i_scan.valid;
            if (w_hit && i_cmd.ins) begin
                r_pend <= 1'b1;
            end else if (w_hit && i_cmd.clr) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit && i_cmd.ins) begin
            r_slot <= i_cmd_slot;
            r_off  <= i_cmd.offset;
            r_ord  <= i_cmd.order;
        end
        if (w_hit && (i_cmd.ins || i_cmd.pdw)) begin
            r_pay <= i_cmd.payload;
        end
        if (w_take) begin
            r_scan.found   <= 1'b1;
            r_scan.key     <= w_key;
            r_scan.handle  <= 5'(IDX);
            r_scan.payload <= r_pay;
        end else begin
            r_scan.found   <= i_scan.found;
            r_scan.key     <= i_scan.key;
            r_scan.handle  <= i_scan.handle;
            r_scan.payload <= i_scan.payload;
        end
    end

    assign o_scan    = r_scan;
    assign o_pending = r_pend;
    assign o_offset  = r_off;

endmodule

// ===== rtl/hashed_timer_wheel_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_timer_wheel_top
// Hashed timer wheel: timer entries in a row of cells, scans walk the row.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   opcode handle timeout ...
//   out      output     o_out_valid / i_out_stall kind expired_handle ... last
//   cfg      input      i_cfg_we                  i_cfg_index i_cfg_wdata
//
// One item at a time: the input stalls until the item is done. Cancel, is-set,
// data-only update, skipped or failed set/update, unused opcodes and a query
// with nothing pending go from decode straight to output; an insert first waits
// on the divider. A query with timers pending scans the row of cells once.
// Advance divides, then scans the row once per wheel step and per expired timer.
// Reset is synchronous and clears all control state; no clearing pass.
// A stalled output holds the item; the block waits on it before the next.
// ----------------------------------------------------------------------------
module hashed_timer_wheel_top
    import htw_pkg::*;
#(
    parameter int unsigned NUM_SLOTS   = DEF_NUM_SLOTS,
    parameter int unsigned NUM_HANDLES = DEF_NUM_HANDLES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [4:0]  i_handle,
    input  logic [31:0] i_timeout,
    input  logic [31:0] i_user_data,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_now,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [4:0]  o_expired_handle,
    output logic [31:0] o_expired_data,
    output logic        o_was_pending,
    output logic        o_updated,
    output logic [31:0] o_next_timeout,
    output logic [1:0]  o_error,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [17:0] i_cfg_wdata
);

    localparam int unsigned SW    = $clog2(NUM_SLOTS);
    localparam int unsigned HW    = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
    localparam int unsigned LIM_W = $clog2(GRAN_MAX * NUM_SLOTS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DEC   = 10'b00_0000_0010,
        S_DIV   = 10'b00_0000_0100,
        S_INS   = 10'b00_0000_1000,
        S_STEP  = 10'b00_0001_0000,
        S_SCAN  = 10'b00_0010_0000,
        S_FOUND = 10'b00_0100_0000,
        S_QMUL  = 10'b00_1000_0000,
        S_QFIN  = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [9:0]    r_gran;
    logic [17:0]   r_maxto;
    logic [LIM_W-1:0] r_max_eff;
    logic [2:0]    r_op;
    logic [4:0]    r_handle;
    logic [31:0]   r_timeout;
    logic [31:0]   r_ud;
    logic [1:0]    r_mode;
    logic [31:0]   r_now;
    logic          r_was;
    logic [31:0]   r_actual;
    logic [15:0]   r_ic;
    logic [SW-1:0] r_wi;
    logic [31:0]   r_wt;
    logic [6:0]    r_count;
    logic [31:0]   r_steps;
    logic [31:0]   r_k;
    logic [31:0]   r_target;
    logic          r_query;
    logic          r_launch;
    t_scan         r_fnd;
    logic [SW-1:0] r_dist;
    logic [LIM_W-1:0] r_v;
    t_res          r_hold;
    logic          r_have;
    t_res          r_out;
    logic          r_ov;
    logic          r_olast;

    logic [9:0]       w_geff;
    logic [LIM_W-1:0] w_lim;
    logic [HW-1:0]    w_idx;
    logic             w_hok;
    logic             w_was;
    logic [31:0]      w_off;
    logic [31:0]      w_diff;
    logic [32:0]      w_a;
    logic             w_long;
    logic             w_set_skip;
    logic             w_pd_only;
    logic             w_cmp_fail;
    logic             w_ins_go;
    logic             w_div_start;
    logic [31:0]      w_dividend;
    logic             w_div_done;
    logic [31:0]      w_quot;
    logic [9:0]       w_rem;
    logic [SW:0]      w_sum;
    logic [SW-1:0]    w_slot;
    logic             w_out_free;
    logic [31:0]      w_td;
    logic [31:0]      w_nt;
    t_cmd             w_cmd;
    t_scan            w_link [NUM_HANDLES+1];
    logic             w_pend [NUM_HANDLES];
    logic [31:0]      w_offs [NUM_HANDLES];

    assign w_geff = (r_gran == 10'd0) ? 10'd1 : r_gran;
    assign w_lim  = LIM_W'(LIM_W'(w_geff) * LIM_W'(NUM_SLOTS)) - LIM_W'(1);

    assign w_idx = HW'({1'b0, r_handle});
    assign w_hok = {2'b0, r_handle} < 7'(NUM_HANDLES);
    assign w_was = w_hok && w_pend[w_idx];
    assign w_off = w_offs[w_idx];

    assign w_diff = (r_count == 7'd0) ? 32'd0 : r_now - r_wt;
    assign w_a    = {1'b0, r_timeout} + {1'b0, w_diff};
    assign w_long = w_a > 33'(r_max_eff);

    assign w_set_skip = r_op == OP_SET && r_mode != MODE_ALWAYS && w_was;
    assign w_pd_only  = r_op == OP_UPD && w_was && r_mode == MODE_DATA;
    assign w_cmp_fail = r_op == OP_UPD && w_was &&
                        ((r_mode == MODE_LATER && !(w_a[31:0] > w_off)) ||
                         (r_mode == MODE_SOONER && !(w_a[31:0] < w_off)));
    assign w_ins_go   = w_hok && (r_op == OP_SET || r_op == OP_UPD) && !w_set_skip &&
                        !w_pd_only && !w_long && !w_cmp_fail;

    assign w_div_start = r_state == S_DEC && (r_op == OP_ADV || w_ins_go);
    assign w_dividend  = (r_op == OP_ADV) ? r_now - r_wt : w_a[31:0];

    assign w_sum  = (SW+1)'(r_wi) + (SW+1)'(w_quot[SW-1:0]);
    assign w_slot = (w_sum >= (SW+1)'(NUM_SLOTS)) ? SW'(w_sum - (SW+1)'(NUM_SLOTS))
                                                 : SW'(w_sum);

    assign w_out_free = !r_ov || !i_out_stall;

    assign w_td = (r_now > r_wt) ? r_now - r_wt : r_wt - r_now;
    assign w_nt = (w_td > 32'(r_v)) ? 32'd0 : 32'(r_v) - w_td;

    always_comb begin
        w_cmd         = '0;
        w_cmd.handle  = r_handle;
        w_cmd.offset  = r_actual;
        w_cmd.payload = r_ud;
        w_cmd.order   = r_ic;
        unique case (r_state)
            S_DEC: begin
                w_cmd.pdw = w_hok && w_pd_only;
                w_cmd.clr = w_hok && r_op == OP_CAN && w_was;
            end
            S_INS: begin
                w_cmd.ins = 1'b1;
            end
            S_FOUND: begin
                w_cmd.handle = r_fnd.handle;
                w_cmd.clr    = !r_have || w_out_free;
            end
            default: begin
            end
        endcase
    end

    assign w_link[0] = '{valid: r_launch, found: 1'b0, key: '0, handle: '0, payload: '0};

    generate
        for (genvar gi = 0; gi < NUM_HANDLES; gi++) begin : g_cell
            htw_cell #(
                .NUM_SLOTS (NUM_SLOTS),
                .IDX       (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_cmd_slot (w_slot),
                .i_wi       (r_wi),
                .i_ic       (r_ic),
                .i_query    (r_query),
                .i_scan     (w_link[gi]),
                .o_scan     (w_link[gi+1]),
                .o_pending  (w_pend[gi]),
                .o_offset   (w_offs[gi])
            );
        end
    endgenerate

    htw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_geff),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_DEC;
            S_DEC: begin
                if (w_div_start) begin
                    n_state = S_DIV;
                end else if (r_op == OP_NEXT && r_count != 7'd0) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV:   if (w_div_done) n_state = (r_op == OP_ADV) ? S_STEP : S_INS;
            S_INS:   n_state = S_OUT;
            S_STEP:  n_state = (r_k < r_steps && r_count != 7'd0) ? S_SCAN : S_OUT;
            S_SCAN: begin
                if (w_link[NUM_HANDLES].valid) begin
                    if (r_query) begin
                        n_state = S_QMUL;
                    end else if (w_link[NUM_HANDLES].found) begin
                        n_state = S_FOUND;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_FOUND: if (!r_have || w_out_free) n_state = S_SCAN;
            S_QMUL:  n_state = S_QFIN;
            S_QFIN:  n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gran    <= GRAN_RESET;
            r_maxto   <= MAXTO_RESET;
            r_ic      <= '0;
            r_wi      <= '0;
            r_wt      <= '0;
            r_count   <= '0;
            r_launch  <= 1'b0;
            r_have    <= 1'b0;
            r_ov      <= 1'b0;
            r_query   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRAN:  r_gran  <= i_cfg_wdata[9:0];
                    CFG_MAXTO: r_maxto <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_DEC: begin
                    if (r_op == OP_NEXT) begin
                        r_query  <= 1'b1;
                        r_launch <= r_count != 7'd0;
                    end else if (w_hok && r_op <= OP_ISSET && r_op != OP_ADV) begin
                        if ((r_op == OP_SET || r_op == OP_UPD) && !w_set_skip &&
                            !w_pd_only && r_count == 7'd0) begin
                            r_wt <= r_now;
                            r_wi <= '0;
                        end
                        if (r_op == OP_CAN && w_was) r_count <= r_count - 7'd1;
                    end
                    if (r_op == OP_ADV) r_query <= 1'b0;
                end
                S_INS: begin
                    r_ic <= r_ic + 16'd1;
                    if (!r_was) r_count <= r_count + 7'd1;
                end
                S_STEP: begin
                    if (r_k < r_steps && r_count != 7'd0) begin
                        r_launch <= 1'b1;
                    end else begin
                        r_wt <= r_target;
                    end
                end
                S_SCAN: begin
                    if (w_link[NUM_HANDLES].valid && !r_query &&
                        !w_link[NUM_HANDLES].found) begin
                        r_wi <= (r_wi == SW'(NUM_SLOTS - 1)) ? '0 : r_wi + SW'(1);
                    end
                end
                S_FOUND: begin
                    if (!r_have || w_out_free) begin
                        if (r_have) r_ov <= 1'b1;
                        r_have   <= 1'b1;
                        r_count  <= r_count - 7'd1;
                        r_launch <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ov   <= 1'b1;
                        r_have <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_max_eff <= ({14'b0, r_maxto} < 32'(w_lim)) ? LIM_W'(r_maxto) : w_lim;
        if (r_state == S_IDLE) begin
            r_op      <= i_opcode;
            r_handle  <= i_handle;
            r_timeout <= i_timeout;
            r_ud      <= i_user_data;
            r_mode    <= i_mode;
            r_now     <= i_now;
        end
        unique case (r_state)
            S_DEC: begin
                r_was    <= w_was;
                r_actual <= w_a[31:0];
                r_k      <= '0;
                r_hold   <= '0;
                if (r_op == OP_NEXT) begin
                    r_hold.kind <= KIND_NEXT;
                    r_hold.nt   <= NONE_PENDING;
                end else if (r_op != OP_ADV && r_op <= OP_ISSET) begin
                    r_hold.handle <= r_handle;
                    if (w_hok) begin
                        r_hold.wp  <= w_was;
                        r_hold.upd <= w_pd_only;
                        if ((r_op == OP_SET || r_op == OP_UPD) && !w_set_skip &&
                            !w_pd_only && w_long) begin
                            r_hold.err <= ERR_LONG;
                        end
                    end
                end
            end
            S_DIV: begin
                r_steps  <= w_quot;
                r_target <= r_now - 32'(w_rem);
            end
            S_INS: begin
                r_hold.upd <= 1'b1;
            end
            S_STEP: begin
                if (!(r_k < r_steps && r_count != 7'd0) && !r_have) r_hold <= '0;
            end
            S_SCAN: begin
                r_fnd  <= w_link[NUM_HANDLES];
                r_dist <= w_link[NUM_HANDLES].key[SW-1:0];
                if (w_link[NUM_HANDLES].valid && !r_query && !w_link[NUM_HANDLES].found) begin
                    r_k <= r_k + 32'd1;
                end
            end
            S_FOUND: begin
                if (!r_have || w_out_free) begin
                    if (r_have) begin
                        r_out   <= r_hold;
                        r_olast <= 1'b0;
                    end
                    r_hold <= '{kind: KIND_EXPIRE, handle: r_fnd.handle, data: r_fnd.payload,
                                wp: 1'b1, upd: 1'b0, nt: 32'd0, err: ERR_NONE};
                end
            end
            S_QMUL: begin
                r_v <= LIM_W'(LIM_W'((SW+1)'(r_dist) + (SW+1)'(1)) * LIM_W'(w_geff));
            end
            S_QFIN: begin
                r_hold.nt  <= w_nt;
                r_hold.err <= (w_nt > 32'(r_max_eff)) ? ERR_RANGE : ERR_NONE;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out   <= r_hold;
                    r_olast <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall       = r_state != S_IDLE;
    assign o_out_valid      = r_ov;
    assign o_kind           = r_out.kind;
    assign o_expired_handle = r_out.handle;
    assign o_expired_data   = r_out.data;
    assign o_was_pending    = r_out.wp;
    assign o_updated        = r_out.upd;
    assign o_next_timeout   = r_out.nt;
    assign o_error          = r_out.err;
    assign o_last           = r_olast;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the hashed timer wheel. A scoreboard class keeps its
// own copy of the wheel and predicts the result items of every accepted input
// item; results are compared field by field in order. A directed sequence is
// followed by random phases under several granularity / max timeout settings,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
    import htw_pkg::*;

    localparam int          NSLOT       = 256;
    localparam int          NHND        = 32;
    localparam int          WDOG_LIMIT  = 100000;
    localparam logic [1:0]  MODE_IFNP   = 2'd1;
    localparam logic [1:0]  MODE_UPDALL = 2'd1;
    localparam logic [2:0]  OP_BAD6     = 3'd6;
    localparam logic [2:0]  OP_BAD7     = 3'd7;

    class htw_scoreboard;
        bit [9:0]  gran;
        bit [17:0] maxto;
        bit        pend[NHND];
        bit [7:0]  slot[NHND];
        bit [31:0] offs[NHND];
        bit [31:0] pay[NHND];
        bit [15:0] ord[NHND];
        bit [15:0] ins_cnt;
        bit [7:0]  widx;
        bit [31:0] wtime;
        int        pcount;
        t_res      exp_q[$];
        bit        exp_last[$];
        int        errors;

        function void clear();
            gran = GRAN_RESET;
            maxto = MAXTO_RESET;
            foreach (pend[i]) pend[i] = 0;
            ins_cnt = 0;
            widx = 0;
            wtime = 0;
            pcount = 0;
            errors = 0;
        endfunction

        function bit [31:0] geff();
            return (gran == 0) ? 32'd1 : 32'(gran);
        endfunction

        function bit [31:0] meff();
            bit [31:0] lim;
            lim = geff() * NSLOT - 1;
            return (32'(maxto) < lim) ? 32'(maxto) : lim;
        endfunction

        function bit offset_ok(bit [31:0] tmo, bit [31:0] now, output bit [31:0] act);
            bit [63:0] a;
            if (pcount == 0) begin
                wtime = now;
                widx = 0;
            end
            a = 64'(tmo) + 64'(32'(now - wtime));
            act = a[31:0];
            return a <= 64'(meff());
        endfunction

        function void insert(int h, bit [31:0] act, bit was);
            slot[h] = 8'((32'(widx) + act / geff()) % NSLOT);
            offs[h] = act;
            ord[h] = ins_cnt;
            ins_cnt++;
            pend[h] = 1;
            if (!was) pcount++;
        endfunction

        function void push(bit [1:0] kind, bit [4:0] h, bit [31:0] d, bit wp, bit upd,
                           bit [31:0] nt, bit [1:0] err);
            t_res r;
            r.kind = kind; r.handle = h; r.data = d; r.wp = wp;
            r.upd = upd; r.nt = nt; r.err = err;
            exp_q.push_back(r);
            exp_last.push_back(0);
        endfunction

        function void note(bit [2:0] op, bit [4:0] h, bit [31:0] tmo, bit [31:0] ud,
                           bit [1:0] mode, bit [31:0] now);
            bit [31:0] g, steps, target, act, nt, td;
            bit [63:0] v;
            bit        was, upd;
            bit [1:0]  err;
            int        n, best, d, sdist;
            bit [15:0] age, best_age;
            n = 0;
            if (op == OP_ADV) begin
                g = geff();
                steps = (now - wtime) / g;
                target = wtime + steps * g;
                for (longint k = 0; k < steps && pcount > 0; k++) begin
                    forever begin
                        best = -1;
                        best_age = 0;
                        for (int i = 0; i < NHND; i++) begin
                            if (!pend[i] || slot[i] != widx) continue;
                            age = ins_cnt - ord[i];
                            if (best < 0 || age < best_age) begin
                                best = i;
                                best_age = age;
                            end
                        end
                        if (best < 0 || n >= NHND) break;
                        push(KIND_EXPIRE, 5'(best), pay[best], 1, 0, 0, ERR_NONE);
                        n++;
                        pend[best] = 0;
                        pcount--;
                    end
                    widx++;
                    wtime += g;
                end
                wtime = target;
                if (n == 0) push(KIND_STATUS, 0, 0, 0, 0, 0, ERR_NONE);
            end else if (op == OP_NEXT) begin
                nt = NONE_PENDING;
                err = ERR_NONE;
                if (pcount > 0) begin
                    d = NSLOT;
                    for (int i = 0; i < NHND; i++) begin
                        if (!pend[i]) continue;
                        sdist = (int'(slot[i]) + NSLOT - int'(widx)) % NSLOT;
                        if (sdist < d) d = sdist;
                    end
                    if (d >= NSLOT) d = 0;
                    v = 64'(d + 1) * 64'(geff());
                    td = (now > wtime) ? now - wtime : wtime - now;
                    v = (64'(td) > v) ? 64'd0 : v - 64'(td);
                    nt = v[31:0];
                    if (v > 64'(meff())) err = ERR_RANGE;
                end
                push(KIND_NEXT, 0, 0, 0, 0, nt, err);
            end else if (op > OP_ISSET) begin
                push(KIND_STATUS, 0, 0, 0, 0, 0, ERR_NONE);
            end else begin
                was = pend[h];
                upd = 0;
                err = ERR_NONE;
                if (op == OP_SET) begin
                    if (mode == MODE_ALWAYS || !was) begin
                        if (offset_ok(tmo, now, act)) begin
                            pay[h] = ud;
                            insert(h, act, was);
                            upd = 1;
                        end else err = ERR_LONG;
                    end
                end else if (op == OP_UPD) begin
                    if (was && mode == MODE_DATA) begin
                        pay[h] = ud;
                        upd = 1;
                    end else if (!offset_ok(tmo, now, act)) begin
                        err = ERR_LONG;
                    end else if (!was || mode == MODE_UPDALL ||
                                 (mode == MODE_LATER && act > offs[h]) ||
                                 (mode == MODE_SOONER && act < offs[h])) begin
                        pay[h] = ud;
                        insert(h, act, was);
                        upd = 1;
                    end
                end else if (op == OP_CAN) begin
                    if (was) begin
                        pend[h] = 0;
                        pcount--;
                    end
                end
                push(KIND_STATUS, h, 0, was, upd, 0, err);
            end
            exp_last[$] = 1;
        endfunction

        function void cmp(string name, bit [31:0] e, bit [31:0] a);
            if (e !== a) begin
                $display("%0t: mismatch %s expected %0h actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check(t_res r, bit lst);
            t_res e;
            bit el;
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected result item expected none actual %p", $time, r);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            el = exp_last.pop_front();
            cmp("kind", e.kind, r.kind);
            cmp("handle", e.handle, r.handle);
            cmp("data", e.data, r.data);
            cmp("was_pending", e.wp, r.wp);
            cmp("updated", e.upd, r.upd);
            cmp("next_timeout", e.nt, r.nt);
            cmp("error", e.err, r.err);
            cmp("last", el, lst);
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall;
    logic [2:0]  opcode;
    logic [4:0]  handle;
    logic [31:0] timeout, user_data, now;
    logic [1:0]  mode;
    logic        out_valid, out_stall;
    logic [1:0]  kind, err;
    logic [4:0]  exp_handle;
    logic [31:0] exp_data, next_to;
    logic        was_pend, updated, last;
    logic        cfg_we, cfg_index;
    logic [17:0] cfg_wdata;

    htw_scoreboard wheel_sb;
    bit [31:0]     cur_now;
    int            idle_cycles;
    int            stall_left;

    hashed_timer_wheel_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(opcode), .i_handle(handle), .i_timeout(timeout),
        .i_user_data(user_data), .i_mode(mode), .i_now(now),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_kind(kind), .o_expired_handle(exp_handle), .o_expired_data(exp_data),
        .o_was_pending(was_pend), .o_updated(updated), .o_next_timeout(next_to),
        .o_error(err), .o_last(last),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // input and output monitor, stall generation and watchdog
    always @(posedge clk) begin
        t_res r;
        bit   active;
        active = 0;
        if (rst_n && in_valid && !in_stall) begin
            wheel_sb.note(opcode, handle, timeout, user_data, mode, now);
            active = 1;
        end
        if (rst_n && out_valid && !out_stall) begin
            r.kind = kind; r.handle = exp_handle; r.data = exp_data; r.wp = was_pend;
            r.upd = updated; r.nt = next_to; r.err = err;
            wheel_sb.check(r, last);
            active = 1;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2:  stall_left = $urandom_range(0, 2);
                3:        stall_left = $urandom_range(8, 40);
                default:  stall_left = 0;
            endcase
            out_stall <= (stall_left > 0);
        end
        idle_cycles = active ? 0 : idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send(bit [2:0] op, bit [4:0] h, bit [31:0] tmo, bit [31:0] ud,
                        bit [1:0] md, bit [31:0] t);
        opcode <= op; handle <= h; timeout <= tmo; user_data <= ud; mode <= md; now <= t;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic gap();
        int n;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: n = $urandom_range(1, 3);
            5:             n = $urandom_range(10, 40);
            default:       n = 0;
        endcase
        if (n > 0) begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (wheel_sb.exp_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_cfg(bit [9:0] g, bit [17:0] m);
        cfg_we <= 1; cfg_index <= CFG_GRAN; cfg_wdata <= 18'(g);
        @(posedge clk);
        wheel_sb.gran = g;
        cfg_index <= CFG_MAXTO; cfg_wdata <= m;
        @(posedge clk);
        wheel_sb.maxto = m;
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic random_item();
        bit [2:0]  op;
        bit [31:0] tmo, t;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_SET;
        else if (pick < 50) op = OP_UPD;
        else if (pick < 60) op = OP_CAN;
        else if (pick < 80) op = OP_ADV;
        else if (pick < 88) op = OP_NEXT;
        else if (pick < 95) op = OP_ISSET;
        else                op = $urandom_range(0, 1) ? OP_BAD6 : OP_BAD7;
        cur_now += $urandom_range(0, 3 * wheel_sb.geff());
        t = ($urandom_range(0, 19) == 0) ? $urandom : cur_now;
        pick = $urandom_range(0, 9);
        if (pick < 8)       tmo = $urandom_range(0, wheel_sb.meff() + wheel_sb.geff());
        else if (pick == 8) tmo = $urandom;
        else                tmo = $urandom_range(0, 3);
        send(op, 5'($urandom), tmo, $urandom, 2'($urandom), t);
        gap();
    endtask

    initial begin
        bit [31:0] m;
        wheel_sb = new();
        wheel_sb.clear();
        rst_n = 0;
        in_valid = 0; opcode = 0; handle = 0; timeout = 0; user_data = 0; mode = 0; now = 0;
        out_stall = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
        idle_cycles = 0; stall_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed part
        send(OP_NEXT, 0, 0, 0, MODE_ALWAYS, 100);
        send(OP_ADV, 0, 0, 0, MODE_ALWAYS, 200);
        send(OP_SET, 0, 0, 32'hFFFF_FFFF, MODE_ALWAYS, 32'hFFFF_FFF0);
        send(OP_SET, 31, 3825, 32'h1234_5678, MODE_ALWAYS, 32'hFFFF_FFF0);
        send(OP_SET, 1, 3826, 32'hAAAA_5555, MODE_ALWAYS, 32'hFFFF_FFF0);
        send(OP_SET, 0, 10, 32'h5555_AAAA, MODE_IFNP, 32'hFFFF_FFF2);
        send(OP_SET, 2, 32'hFFFF_FFFF, 1, MODE_ALWAYS, 32'hFFFF_FFF2);
        send(OP_UPD, 0, 0, 32'hDEAD_BEEF, MODE_DATA, 32'hFFFF_FFF4);
        send(OP_UPD, 31, 100, 2, MODE_LATER, 32'hFFFF_FFF4);
        send(OP_UPD, 31, 200, 3, MODE_SOONER, 32'hFFFF_FFF4);
        send(OP_UPD, 31, 50, 4, MODE_SOONER, 32'hFFFF_FFF4);
        send(OP_UPD, 3, 60, 5, MODE_UPDALL, 32'hFFFF_FFF4);
        send(OP_SET, 4, 60, 6, MODE_ALWAYS, 32'hFFFF_FFF4);
        send(OP_ISSET, 4, 0, 0, MODE_ALWAYS, 0);
        send(OP_NEXT, 0, 0, 0, MODE_ALWAYS, 32'hFFFF_FF00);
        send(OP_NEXT, 0, 0, 0, MODE_ALWAYS, 32'hFFFF_FFF4);
        send(OP_CAN, 31, 0, 0, MODE_ALWAYS, 0);
        send(OP_CAN, 31, 0, 0, MODE_ALWAYS, 0);
        send(OP_BAD6, 7, 0, 0, MODE_ALWAYS, 0);
        send(OP_BAD7, 7, 0, 0, MODE_ALWAYS, 0);
        send(OP_ADV, 0, 0, 0, MODE_ALWAYS, 32'h0000_0100);
        send(OP_NEXT, 0, 0, 0, MODE_ALWAYS, 32'h0000_0100);
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_cfg(10'd1, 18'd0);
                1: write_cfg(10'd1, 18'd300);
                2: write_cfg(10'd1000, 18'd255000);
                3: write_cfg(10'd7, 18'd1000);
                4: write_cfg(10'd1023, 18'h3FFFF);
                default: write_cfg(GRAN_RESET, MAXTO_RESET);
            endcase
            cur_now = $urandom;
            repeat (55) random_item();
            m = wheel_sb.meff() + wheel_sb.geff() * 300;
            send(OP_ADV, 0, 0, 0, MODE_ALWAYS, cur_now + m);
            cur_now += m;
            drain();
        end

        if (wheel_sb.errors == 0 && wheel_sb.exp_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
